/* src/adrp_pkg.sv */
// ----------------------------------------------------------------------------
// adrp_pkg
// Shared types and constants for the ADRP/ADD reference scanner.
// ----------------------------------------------------------------------------
package adrp_pkg;

    localparam int LOOKAHEAD_DEF   = 7;
    localparam int MATCH_LIMIT_DEF = 8;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int ADDR_W     = 64;
    localparam int WORD_W     = 32;
    localparam int SEG_W      = 32;
    localparam int MAXM_W     = 4;
    localparam int DIST_W     = 3;
    localparam int CFG_IDX_W  = 8;
    localparam int PAGE_SHIFT = 12;

    localparam logic [WORD_W-1:0] ADRP_MASK = 32'h9F00_0000;
    localparam logic [WORD_W-1:0] ADRP_OPC  = 32'h9000_0000;
    localparam logic [WORD_W-1:0] ADD_MASK  = 32'hFFC0_0000;
    localparam logic [WORD_W-1:0] ADD_OPC   = 32'h9100_0000;
    localparam logic [SEG_W-1:0]  SEG_MIN   = 32'd32;

    localparam logic [MAXM_W-1:0] MAX_MATCHES_RST = 4'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ADDRESS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MATCHES    = 8'd1;

    localparam logic KIND_WORD    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [WORD_W-1:0] instr_word;
        logic [ADDR_W-1:0] word_address;
        logic [SEG_W-1:0]  seg_bytes_left;
    } in_beat_t;

    typedef struct packed {
        logic [ADDR_W-1:0] ref_address;
        logic [DIST_W-1:0] add_distance;
        logic              last_of_run;
    } out_beat_t;

endpackage

/* src/adrp_job_fifo.sv */
// ----------------------------------------------------------------------------
// adrp_job_fifo
// Small register FIFO holding match jobs between front and back.
// ----------------------------------------------------------------------------
module adrp_job_fifo #(
    parameter int WIDTH = 71,
    parameter int DEPTH = adrp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* src/adrp_front.sv */
// ----------------------------------------------------------------------------
// adrp_front
// Instruction window, ADRP/ADD classification and match-limit trimming.
// ----------------------------------------------------------------------------
module adrp_front #(
    parameter int LOOKAHEAD   = adrp_pkg::LOOKAHEAD_DEF,
    parameter int MATCH_LIMIT = adrp_pkg::MATCH_LIMIT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  adrp_pkg::in_beat_t            in_data,
    input  logic [adrp_pkg::ADDR_W-1:0]   target_address,
    input  logic [adrp_pkg::MAXM_W-1:0]   max_matches,
    output logic                          job_push,
    output logic [adrp_pkg::ADDR_W-1:0]   job_addr,
    output logic [LOOKAHEAD-1:0]          job_mask,
    input  logic                          job_full
);
    import adrp_pkg::*;

    localparam int WIN    = LOOKAHEAD + 1;
    localparam int FILL_W = $clog2(WIN + 1);
    localparam int CNT_W  = $clog2(MATCH_LIMIT + 1);
    localparam int LIM_W  = (CNT_W > MAXM_W) ? CNT_W : MAXM_W;
    localparam int PAGE_W = ADDR_W - PAGE_SHIFT;

    logic [WORD_W-1:0] win_word_reg [WIN];
    logic [ADDR_W-1:0] win_addr_reg [WIN];
    logic [WIN-1:0]    win_elig_reg;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              test_pending_reg, test_pending_next;

    logic              accept, acc_word, acc_restart, test_go;
    logic [20:0]       imm21;
    logic [PAGE_W-1:0] page_hi;
    logic              head_hit;
    logic [LOOKAHEAD-1:0] add_hit;
    logic [LIM_W-1:0]  limit, remaining, kept_cnt;
    logic [LOOKAHEAD-1:0] kept_mask;

    assign in_ready    = !test_pending_reg || !job_full;
    assign accept      = in_valid && in_ready;
    assign acc_word    = accept && (in_data.kind == KIND_WORD);
    assign acc_restart = accept && (in_data.kind == KIND_RESTART);
    assign test_go     = test_pending_reg && !job_full;

    // head of a full window: ADRP page check
    assign imm21   = {win_word_reg[0][23:5], win_word_reg[0][30:29]};
    assign page_hi = win_addr_reg[0][ADDR_W-1:PAGE_SHIFT]
                   + {{(PAGE_W - 21){imm21[20]}}, imm21};
    assign head_hit = win_elig_reg[0]
                   && ((win_word_reg[0] & ADRP_MASK) == ADRP_OPC)
                   && (page_hi == target_address[ADDR_W-1:PAGE_SHIFT]);

    // page low bits are zero, so page + imm12 == target reduces to imm12 == target[11:0]
    always_comb begin
        for (int i = 1; i < WIN; i++) begin
            add_hit[i-1] = ((win_word_reg[i] & ADD_MASK) == ADD_OPC)
                        && (win_word_reg[i][9:5] == win_word_reg[0][4:0])
                        && (win_word_reg[i][21:10] == target_address[PAGE_SHIFT-1:0]);
        end
    end

    always_comb begin
        limit = (LIM_W'(max_matches) < LIM_W'(MATCH_LIMIT)) ? LIM_W'(max_matches)
                                                            : LIM_W'(MATCH_LIMIT);
        remaining = (LIM_W'(count_reg) < limit) ? limit - LIM_W'(count_reg) : '0;
        kept_cnt  = '0;
        kept_mask = '0;
        for (int i = 0; i < LOOKAHEAD; i++) begin
            if (head_hit && add_hit[i] && (kept_cnt < remaining)) begin
                kept_mask[i] = 1'b1;
                kept_cnt     = kept_cnt + 1'b1;
            end
        end
    end

    assign job_push = test_go && (kept_mask != '0);
    assign job_addr = win_addr_reg[0];
    assign job_mask = kept_mask;

    always_comb begin
        fill_next         = fill_reg;
        count_next        = count_reg;
        test_pending_next = test_pending_reg && !test_go;
        if (test_go) begin
            count_next = CNT_W'(LIM_W'(count_reg) + kept_cnt);
        end
        if (acc_word) begin
            fill_next = (fill_reg == FILL_W'(WIN)) ? FILL_W'(WIN) : fill_reg + 1'b1;
            if (fill_reg >= FILL_W'(WIN - 1)) begin
                test_pending_next = 1'b1;
            end
        end
        if (acc_restart) begin
            fill_next  = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg         <= '0;
            count_reg        <= '0;
            test_pending_reg <= 1'b0;
        end else begin
            fill_reg         <= fill_next;
            count_reg        <= count_next;
            test_pending_reg <= test_pending_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_word) begin
            for (int i = 0; i < WIN - 1; i++) begin
                win_word_reg[i] <= win_word_reg[i+1];
                win_addr_reg[i] <= win_addr_reg[i+1];
                win_elig_reg[i] <= win_elig_reg[i+1];
            end
            win_word_reg[WIN-1] <= in_data.instr_word;
            win_addr_reg[WIN-1] <= in_data.word_address;
            win_elig_reg[WIN-1] <= (in_data.seg_bytes_left > SEG_MIN);
        end
    end

endmodule

/* src/adrp_back.sv */
// ----------------------------------------------------------------------------
// adrp_back
// Expands one match job into result beats, one per cycle while out_ready allows, with output register.
// ----------------------------------------------------------------------------
module adrp_back #(
    parameter int LOOKAHEAD = adrp_pkg::LOOKAHEAD_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          job_empty,
    input  logic [adrp_pkg::ADDR_W-1:0]   job_addr,
    input  logic [LOOKAHEAD-1:0]          job_mask,
    output logic                          job_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output adrp_pkg::out_beat_t           out_data
);
    import adrp_pkg::*;

    logic                 cur_valid_reg, cur_valid_next;
    logic [ADDR_W-1:0]    cur_addr_reg;
    logic [LOOKAHEAD-1:0] cur_mask_reg, cur_mask_next;
    logic                 out_valid_reg, out_valid_next;
    out_beat_t            out_data_reg;

    logic                 out_free, emit, last, load;
    logic [LOOKAHEAD-1:0] pick, rest;
    logic [DIST_W-1:0]    pick_dist;

    assign out_free = !out_valid_reg || out_ready;
    assign emit     = cur_valid_reg && out_free;
    assign pick     = cur_mask_reg & (~cur_mask_reg + 1'b1);
    assign rest     = cur_mask_reg & ~pick;
    assign last     = (rest == '0);
    assign load     = !job_empty && (!cur_valid_reg || (emit && last));
    assign job_pop  = load;

    always_comb begin
        pick_dist = '0;
        for (int i = 0; i < LOOKAHEAD; i++) begin
            if (pick[i]) begin
                pick_dist = pick_dist | DIST_W'(i + 1);
            end
        end
    end

    always_comb begin
        cur_valid_next = cur_valid_reg;
        cur_mask_next  = cur_mask_reg;
        if (emit) begin
            cur_mask_next = rest;
            if (last) begin
                cur_valid_next = 1'b0;
            end
        end
        if (load) begin
            cur_valid_next = 1'b1;
            cur_mask_next  = job_mask;
        end
        out_valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_mask_reg <= cur_mask_next;
        if (load) begin
            cur_addr_reg <= job_addr;
        end
        if (emit) begin
            out_data_reg.ref_address  <= cur_addr_reg;
            out_data_reg.add_distance <= pick_dist;
            out_data_reg.last_of_run  <= last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* src/adrp_add_reference_scanner.sv */
// ----------------------------------------------------------------------------
// adrp_add_reference_scanner
// Finds ADRP + ADD immediate pairs that form a given target address.
//
// Input channel (s_*): one beat per instruction word with its address and
// segment bytes left, or a restart beat that empties the window and clears
// the match count. Up to one beat is taken per cycle.
// Result channel (m_*): one beat per matching ADD, carrying the ADRP address,
// the word distance to the ADD and a last-of-run flag for the final result
// caused by one input beat. Results are given in stream order.
// Config channel (cfg_*): register 0 target address, register 1 match
// limit; always ready. Registers are written while the block is idle; the user
// must see to this, as the block does not enforce it. Throughput: 1 input beat
// per cycle while s_ready is high; the back end gives 1 result per cycle under
// m_ready high. A 4-entry job queue absorbs bursts; when it is full and a test
// is due, s_ready drops. Under m_ready low the result register holds its beat.
// Reset empties window, queue and output and restores the register defaults.
// ----------------------------------------------------------------------------
module adrp_add_reference_scanner #(
    parameter int LOOKAHEAD   = adrp_pkg::LOOKAHEAD_DEF,
    parameter int MATCH_LIMIT = adrp_pkg::MATCH_LIMIT_DEF,
    parameter int QUEUE_DEPTH = adrp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  adrp_pkg::in_beat_t             s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output adrp_pkg::out_beat_t            m_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [adrp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [adrp_pkg::ADDR_W-1:0]    cfg_data
);
    import adrp_pkg::*;

    localparam int JOB_W = ADDR_W + LOOKAHEAD;

    logic [ADDR_W-1:0]    target_reg;
    logic [MAXM_W-1:0]    max_matches_reg;

    logic                 push, full, pop, empty;
    logic [ADDR_W-1:0]    push_addr;
    logic [LOOKAHEAD-1:0] push_mask;
    logic [JOB_W-1:0]     pop_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg      <= '0;
            max_matches_reg <= MAX_MATCHES_RST;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_TARGET_ADDRESS) begin
                target_reg <= cfg_data;
            end else if (cfg_index == CFG_MAX_MATCHES) begin
                max_matches_reg <= cfg_data[MAXM_W-1:0];
            end
        end
    end

    adrp_front #(
        .LOOKAHEAD   (LOOKAHEAD),
        .MATCH_LIMIT (MATCH_LIMIT)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_valid),
        .in_ready       (s_ready),
        .in_data        (s_data),
        .target_address (target_reg),
        .max_matches    (max_matches_reg),
        .job_push       (push),
        .job_addr       (push_addr),
        .job_mask       (push_mask),
        .job_full       (full)
    );

    adrp_job_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({push_addr, push_mask}),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_job),
        .empty     (empty)
    );

    adrp_back #(
        .LOOKAHEAD (LOOKAHEAD)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_empty (empty),
        .job_addr  (pop_job[JOB_W-1:LOOKAHEAD]),
        .job_mask  (pop_job[LOOKAHEAD-1:0]),
        .job_pop   (pop),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

/* src/adrp_checker.sv */
// ----------------------------------------------------------------------------
// adrp_checker
// Port-level checks for the reference scanner, bound to the top level.
// ----------------------------------------------------------------------------
module adrp_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input adrp_pkg::out_beat_t m_data
);
    import adrp_pkg::*;

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_dist_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.add_distance != '0)
        else $error("zero add distance");

    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last_of_run |=>
            m_valid && (m_data.ref_address == $past(m_data.ref_address))
            && (m_data.add_distance > $past(m_data.add_distance)))
        else $error("run broken before its last beat");

endmodule

bind adrp_add_reference_scanner adrp_checker u_adrp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ADRP + ADD reference scanner.
//
// A queue of pending beats (instruction words, restarts and register writes)
// feeds a clocked driver with random gaps. Every accepted word runs through a
// local model of the eight-word window, and the ADRP hits it predicts wait in
// order for the monitor, which stalls m_ready at random and compares each
// result beat field by field. Register writes are issued only once the block
// has gone quiet. A short directed part is followed by random phases under
// several target and match-limit settings.
// ----------------------------------------------------------------------------
module tb;
    import adrp_pkg::*;

    localparam int WIN      = LOOKAHEAD_DEF + 1;
    localparam int SETTLE   = 40;
    localparam int WATCHDOG = 4000;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [ADDR_W-1:0]    val;
        in_beat_t             beat;
    } stim_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_beat_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_beat_t            m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ADDR_W-1:0]    cfg_data  = '0;

    stim_t     beat_q[$];
    out_beat_t hit_q[$];

    // scanner copy
    logic [ADDR_W-1:0] tgt_addr  = '0;
    logic [MAXM_W-1:0] max_match = MAX_MATCHES_RST;
    logic [WORD_W-1:0] win_word[WIN];
    logic [ADDR_W-1:0] win_addr[WIN];
    bit                win_elig[WIN];
    int                win_fill  = 0;
    int                hit_count = 0;

    int n_items  = 0;
    int errors   = 0;
    int s_gap    = 0;
    int m_stall  = 0;
    int quiet    = 0;
    int idle_cyc = 0;
    bit s_calm   = 1'b0;
    bit m_calm   = 1'b0;
    bit s_acc, c_acc, m_acc;
    stim_t nxt;

    adrp_add_reference_scanner i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic logic [ADDR_W-1:0] adrp_page(logic [WORD_W-1:0] w,
                                                    logic [ADDR_W-1:0] pc);
        logic [20:0]       imm;
        logic [ADDR_W-1:0] sext;
        imm  = {w[23:5], w[30:29]};
        sext = {{43{imm[20]}}, imm};
        return (pc & ~64'hFFF) + (sext << PAGE_SHIFT);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
        if (idx == CFG_TARGET_ADDRESS) tgt_addr = val;
        else if (idx == CFG_MAX_MATCHES) max_match = val[MAXM_W-1:0];
    endtask

    task automatic scan_window(input in_beat_t b);
        logic [WORD_W-1:0] w, a;
        logic [ADDR_W-1:0] pc, page;
        logic [4:0]        rd;
        int                limit, k;
        int                dist_q[$];
        out_beat_t         hit;
        if (b.kind == KIND_RESTART) begin
            for (k = 0; k < WIN; k++) win_elig[k] = 1'b0;
            win_fill  = 0;
            hit_count = 0;
            return;
        end
        if (win_fill >= WIN) begin
            for (k = 0; k < WIN - 1; k++) begin
                win_word[k] = win_word[k+1];
                win_addr[k] = win_addr[k+1];
                win_elig[k] = win_elig[k+1];
            end
            win_fill = WIN - 1;
        end
        win_word[win_fill] = b.instr_word;
        win_addr[win_fill] = b.word_address;
        win_elig[win_fill] = b.seg_bytes_left > SEG_MIN;
        win_fill++;
        if (win_fill < WIN) return;
        limit = (max_match < MATCH_LIMIT_DEF) ? max_match : MATCH_LIMIT_DEF;
        w  = win_word[0];
        pc = win_addr[0];
        if (!win_elig[0] || (w & ADRP_MASK) != ADRP_OPC || hit_count >= limit) return;
        page = adrp_page(w, pc);
        if (page != (tgt_addr & ~64'hFFF)) return;
        rd = w[4:0];
        for (k = 1; k <= LOOKAHEAD_DEF && hit_count < limit; k++) begin
            a = win_word[k];
            if ((a & ADD_MASK) == ADD_OPC && a[9:5] == rd &&
                page + 64'(a[21:10]) == tgt_addr) begin
                dist_q = {dist_q, k};
                hit_count++;
            end
        end
        for (k = 0; k < dist_q.size(); k++) begin
            hit.ref_address  = pc;
            hit.add_distance = DIST_W'(dist_q[k]);
            hit.last_of_run  = (k == dist_q.size() - 1);
            hit_q = {hit_q, hit};
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            cfg_valid <= 1'b0;
            s_gap = 0;
            quiet = 0;
        end else begin
            s_acc = s_valid && s_ready;
            c_acc = cfg_valid && cfg_ready;
            if (s_acc) scan_window(s_data);
            if (c_acc) write_reg(cfg_index, cfg_data);
            if (s_acc || c_acc) begin
                if ($urandom_range(0, 29) == 0) s_calm = !s_calm;
                s_gap = s_calm ? 0 : $urandom_range(0, 18);
            end
            quiet = (s_acc || c_acc || s_valid || cfg_valid || (m_valid && m_ready)) ?
                    0 : quiet + 1;
            if ((s_valid && !s_acc) || (cfg_valid && !c_acc)) begin
                // beat still waiting
            end else if (s_gap > 0) begin
                s_gap--;
                s_valid   <= 1'b0;
                cfg_valid <= 1'b0;
            end else if (beat_q.size() > 0 && !beat_q[0].is_cfg) begin
                nxt = beat_q.pop_front();
                s_data    <= nxt.beat;
                s_valid   <= 1'b1;
                cfg_valid <= 1'b0;
            end else if (beat_q.size() > 0 && hit_q.size() == 0 && quiet >= SETTLE) begin
                nxt = beat_q.pop_front();
                cfg_index <= nxt.idx;
                cfg_data  <= nxt.val;
                cfg_valid <= 1'b1;
                s_valid   <= 1'b0;
            end else begin
                s_valid   <= 1'b0;
                cfg_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            m_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (hit_q.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual %h/%0d/%0b",
                             $time, m_data.ref_address, m_data.add_distance,
                             m_data.last_of_run);
                    errors++;
                end else begin
                    if (m_data.ref_address !== hit_q[0].ref_address) begin
                        $display("%0t: ref_address expected %h actual %h", $time,
                                 hit_q[0].ref_address, m_data.ref_address);
                        errors++;
                    end
                    if (m_data.add_distance !== hit_q[0].add_distance) begin
                        $display("%0t: add_distance expected %0d actual %0d", $time,
                                 hit_q[0].add_distance, m_data.add_distance);
                        errors++;
                    end
                    if (m_data.last_of_run !== hit_q[0].last_of_run) begin
                        $display("%0t: last_of_run expected %0b actual %0b", $time,
                                 hit_q[0].last_of_run, m_data.last_of_run);
                        errors++;
                    end
                    void'(hit_q.pop_front());
                end
                if ($urandom_range(0, 29) == 0) m_calm = !m_calm;
                m_stall = m_calm ? 0 : $urandom_range(0, 18);
            end
            if (m_stall > 0) begin
                m_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            m_acc = m_valid && m_ready;
            if ((s_valid && s_ready) || (cfg_valid && cfg_ready) || m_acc) idle_cyc = 0;
            else idle_cyc++;
            if (idle_cyc >= WATCHDOG) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic logic [WORD_W-1:0] adrp_word(logic [20:0] d, logic [4:0] rd);
        return {1'b1, d[1:0], 5'b10000, d[20:2], rd};
    endfunction

    function automatic logic [WORD_W-1:0] add_word(logic [11:0] imm, logic [4:0] rn,
                                                   logic [4:0] rd);
        return {ADD_OPC[31:22], imm, rn, rd};
    endfunction

    function automatic logic [SEG_W-1:0] draw_seg();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '1;
        if (r < 20) return SEG_W'($urandom_range(0, 40));
        return $urandom;
    endfunction

    task automatic push_word(input logic [WORD_W-1:0] w, input logic [ADDR_W-1:0] addr,
                             input logic [SEG_W-1:0] seg);
        stim_t s;
        s.is_cfg              = 1'b0;
        s.idx                 = '0;
        s.val                 = '0;
        s.beat.kind           = KIND_WORD;
        s.beat.instr_word     = w;
        s.beat.word_address   = addr;
        s.beat.seg_bytes_left = seg;
        beat_q = {beat_q, s};
        n_items++;
    endtask

    task automatic push_restart();
        stim_t s;
        s.is_cfg              = 1'b0;
        s.idx                 = '0;
        s.val                 = '0;
        s.beat.kind           = KIND_RESTART;
        s.beat.instr_word     = $urandom;
        s.beat.word_address   = {$urandom, $urandom};
        s.beat.seg_bytes_left = $urandom;
        beat_q = {beat_q, s};
        n_items++;
    endtask

    task automatic push_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
        stim_t s;
        s.is_cfg = 1'b1;
        s.idx    = idx;
        s.val    = val;
        s.beat   = '0;
        beat_q = {beat_q, s};
    endtask

    // ADRP onto the target page (one page off when bad_page) followed by LOOKAHEAD words, mostly ADD candidates
    task automatic push_seq(input logic [ADDR_W-1:0] tgt, input int match_pct,
                            input bit bad_page, input logic [SEG_W-1:0] adrp_seg);
        logic [20:0]       d;
        logic [ADDR_W-1:0] pc;
        logic [4:0]        rn;
        logic [WORD_W-1:0] w;
        int                k;
        d = 21'($urandom);
        if ($urandom_range(0, 1) == 1) d = 21'($urandom_range(0, 15)) - 21'd8;
        pc = ((tgt & ~64'hFFF) - ({{43{d[20]}}, d} << PAGE_SHIFT)) |
             64'($urandom_range(0, 4095));
        rn = 5'($urandom);
        push_word(adrp_word(bad_page ? d + 21'd1 : d, rn), pc, adrp_seg);
        for (k = 1; k <= LOOKAHEAD_DEF; k++) begin
            if ($urandom_range(0, 99) < match_pct) begin
                w = add_word(tgt[11:0], rn, 5'($urandom));
            end else begin
                case ($urandom_range(0, 6))
                    0: w = add_word(tgt[11:0] ^ 12'($urandom_range(1, 4095)), rn,
                                    5'($urandom));
                    1: w = add_word(tgt[11:0], rn ^ 5'($urandom_range(1, 31)),
                                    5'($urandom));
                    2: w = add_word(tgt[11:0], rn, 5'($urandom)) | (32'd1 << 22);
                    3: w = add_word(tgt[11:0], rn, 5'($urandom)) & ~(32'd1 << 31);
                    4: w = add_word(tgt[11:0], rn, 5'($urandom)) | (32'd1 << 29);
                    5: w = adrp_word(d, rn);
                    default: w = $urandom;
                endcase
            end
            push_word(w, pc + 64'(4 * k), draw_seg());
        end
    endtask

    task automatic random_phase(input logic [ADDR_W-1:0] tgt, input int n);
        int base, r;
        base = n_items;
        while (n_items - base < n) begin
            r = $urandom_range(0, 99);
            if (r < 20) begin
                push_restart();
            end else if (r < 80) begin
                push_seq(tgt, $urandom_range(20, 70), $urandom_range(0, 9) == 0, draw_seg());
            end else begin
                repeat ($urandom_range(1, 4)) push_word($urandom, {$urandom, $urandom},
                                                        draw_seg());
            end
        end
    endtask

    task automatic set_max(input logic [MAXM_W-1:0] m);
        logic [ADDR_W-1:0] v;
        v = {$urandom, $urandom};
        v[MAXM_W-1:0] = m;
        push_cfg(CFG_MAX_MATCHES, v);
    endtask

    initial begin
        logic [ADDR_W-1:0] t;
        int k;
        for (k = 0; k < WIN; k++) begin
            win_word[k] = '0;
            win_addr[k] = '0;
            win_elig[k] = 1'b0;
        end

        // directed: full burst, burst cut at the limit, ADRP too close to segment end
        t = {$urandom, $urandom};
        push_cfg(CFG_TARGET_ADDRESS, t);
        set_max(4'd8);
        push_restart();
        push_seq(t, 100, 1'b0, 32'd33);
        push_seq(t, 100, 1'b0, '1);
        push_restart();
        push_word(adrp_word(21'd0, 5'd7), t, SEG_MIN);
        push_word('0, '0, '0);
        push_word('1, '1, '1);
        for (k = 3; k <= LOOKAHEAD_DEF; k++)
            push_word(add_word(t[11:0], 5'd7, 5'($urandom)), t + 64'(4 * k), '1);

        random_phase(t, 90);

        t = {$urandom, $urandom};
        push_cfg(CFG_TARGET_ADDRESS, t);
        set_max(4'd1);
        random_phase(t, 80);

        push_cfg(CFG_TARGET_ADDRESS, '0);
        set_max(4'd15);
        push_cfg(CFG_IDX_W'(2), {$urandom, $urandom});
        push_restart();
        random_phase('0, 80);

        push_cfg(CFG_TARGET_ADDRESS, '1);
        set_max(4'd3);
        push_cfg('1, {$urandom, $urandom});
        random_phase('1, 80);

        t = {$urandom, $urandom};
        push_cfg(CFG_TARGET_ADDRESS, t);
        set_max(4'd0);
        random_phase(t, 60);

        t = {$urandom, $urandom};
        push_cfg(CFG_TARGET_ADDRESS, t);
        set_max(4'($urandom_range(1, 8)));
        push_restart();
        random_phase(t, 90);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (beat_q.size() > 0 || s_valid || cfg_valid || hit_q.size() > 0)
            @(posedge aclk);
        repeat (50) @(posedge aclk);

        if (errors == 0 && hit_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
